// ----- rtl/core/kmwf_pkg.sv -----
`default_nettype none

package kmwf_pkg;

  // fixed field widths
  localparam int ID_W   = 13;
  localparam int CELL_W = 12;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 1;

  // union-find rank field
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_INIT = 4'd1;
  localparam logic [RANK_W-1:0] RANK_TOP  = 4'd15;

  // default grid limits
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] ROWS_RST = 7'd8;
  localparam logic [CFG_W-1:0] COLS_RST = 7'd8;

  // depth of the queue between decoder and union-find engine
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ----- rtl/core/kruskal_maze_wall_filter_top.sv -----
`default_nettype none

// channel   direction  transfer when          payload
// cfg       in         cfg_we high            cfg_index, cfg_data
// in        in         in_valid & in_ready    in_wall_id
// out       out        out_valid & out_ready  first/second cell, removed, complete, bad
//
// decoder: decodes the id and, on a horizontal wall, checks the column one remainder bit
// per cell index bit (12 by default); engine: a wall kept without lookup skips the walk,
// else both root paths are walked, plus a rank step when a union raises a rank; after
// reset the table is cleared one entry a cycle, all MAX_ROWS*MAX_COLS entries
// (4096 by default), with in_ready low; configuration writes are taken throughout; a
// two-entry queue and the output register let either side stall on its own

module kruskal_maze_wall_filter_top #(
  parameter int MAX_ROWS = kmwf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = kmwf_pkg::DEF_MAX_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [kmwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kmwf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [kmwf_pkg::ID_W-1:0]      in_wall_id,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [kmwf_pkg::CELL_W-1:0]         out_first_cell,
  output logic [kmwf_pkg::CELL_W-1:0]         out_second_cell,
  output logic                                out_removed,
  output logic                                out_maze_complete,
  output logic                                out_bad_wall
);

  // cell index width and queue entry width follow from the grid limits
  localparam int SLOTS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(SLOTS);
  localparam int EW    = 3 * AW + 1;

  logic          clear_busy;
  logic          q_push, q_pop, q_full, q_empty;
  logic [EW-1:0] q_wr_data, q_rd_data;

  // decoder: register file, id to cell pair, bounds and last-column checks
  kmwf_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_wall_id (in_wall_id),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  // decoded walls waiting for the engine
  kmwf_queue #(
    .WIDTH (EW),
    .DEPTH (kmwf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // union-find engine with the link/rank table and the output register
  kmwf_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_rd_data),
    .q_pop             (q_pop),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_cell    (out_first_cell),
    .out_second_cell   (out_second_cell),
    .out_removed       (out_removed),
    .out_maze_complete (out_maze_complete),
    .out_bad_wall      (out_bad_wall)
  );

endmodule

`default_nettype wire

// ----- rtl/core/kmwf_ram.sv -----
`default_nettype none

module kmwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/kmwf_front.sv -----
`default_nettype none

module kmwf_front #(
  parameter int MAX_ROWS = kmwf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = kmwf_pkg::DEF_MAX_COLS,
  localparam int SLOTS = MAX_ROWS * MAX_COLS,
  localparam int AW = $clog2(SLOTS),
  localparam int EW = 3 * AW + 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [kmwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kmwf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [kmwf_pkg::ID_W-1:0]      in_wall_id,
  input  wire logic                           clear_busy,
  input  wire logic                           q_full,
  output logic                                q_push,
  output logic      [EW-1:0]                  q_data
);

  localparam int CFG_W = kmwf_pkg::CFG_W;
  localparam int ID_W  = kmwf_pkg::ID_W;
  localparam int NW    = AW + 1;
  localparam int WW    = (ID_W > NW) ? ID_W : NW;
  localparam int PW    = 2 * CFG_W;
  localparam int CNT_W = $clog2(AW);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIM  = 3'd1;
  localparam logic [2:0] F_DEC  = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]       st_r, st_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [CFG_W-1:0] colsc_r, colsc_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [AW-1:0]    h_r, h_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    c1_r, c1_nxt;
  logic [AW-1:0]    c2_r, c2_nxt;
  logic             bad_r, bad_nxt;

  logic [CFG_W-1:0] rows_c, cols_c;
  logic [WW-1:0]    id_w, n_w, col_w, h_w;
  logic [CFG_W:0]   trial;
  logic [CFG_W-1:0] rem_new;

  // clamp grid registers into the supported range
  always_comb begin
    if (rows_r == '0) rows_c = CFG_W'(1);
    else if (int'(rows_r) > MAX_ROWS) rows_c = CFG_W'(MAX_ROWS);
    else rows_c = rows_r;
    if (cols_r == '0) cols_c = CFG_W'(1);
    else if (int'(cols_r) > MAX_COLS) cols_c = CFG_W'(MAX_COLS);
    else cols_c = cols_r;
  end

  assign id_w  = WW'(id_r);
  assign n_w   = WW'(n_r);
  assign col_w = WW'(colsc_r);
  assign h_w   = id_w - n_w;

  // one remainder bit per cycle
  assign trial   = {rem_r, h_r[AW-1]};
  assign rem_new = (trial >= {1'b0, colsc_r}) ? CFG_W'(trial - {1'b0, colsc_r})
                                              : CFG_W'(trial);

  always_comb begin
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    st_nxt    = st_r;
    id_nxt    = id_r;
    colsc_nxt = colsc_r;
    n_nxt     = n_r;
    h_nxt     = h_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    c1_nxt    = c1_r;
    c2_nxt    = c2_r;
    bad_nxt   = bad_r;
    in_ready  = 1'b0;
    q_push    = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        kmwf_pkg::REG_ROWS: rows_nxt = cfg_data;
        kmwf_pkg::REG_COLS: cols_nxt = cfg_data;
        default: ;
      endcase
    end

    case (st_r)
      F_IDLE: begin
        in_ready = !clear_busy;
        if (in_valid && !clear_busy) begin
          id_nxt = in_wall_id;
          st_nxt = F_DIM;
        end
      end
      F_DIM: begin
        n_nxt     = NW'(PW'(rows_c) * PW'(cols_c));
        colsc_nxt = cols_c;
        st_nxt    = F_DEC;
      end
      F_DEC: begin
        c1_nxt  = '0;
        c2_nxt  = '0;
        bad_nxt = 1'b1;
        st_nxt  = F_PUSH;
        if (id_w < n_w) begin
          // wall to the cell below
          if (id_w < n_w - col_w) begin
            c1_nxt  = AW'(id_w);
            c2_nxt  = AW'(id_w + col_w);
            bad_nxt = 1'b0;
          end
        end else if (h_w < n_w) begin
          // wall to the right: find the column first
          h_nxt   = AW'(h_w);
          c1_nxt  = AW'(h_w);
          rem_nxt = '0;
          cnt_nxt = '0;
          bad_nxt = 1'b0;
          st_nxt  = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt = rem_new;
        h_nxt   = h_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(AW - 1)) begin
          if (rem_new == colsc_r - CFG_W'(1)) begin
            bad_nxt = 1'b1;
            c1_nxt  = '0;
            c2_nxt  = '0;
          end else begin
            c2_nxt = c1_r + AW'(1);
          end
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_push = !q_full;
        if (!q_full) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  assign q_data = {bad_r, AW'(n_r - NW'(1)), c2_r, c1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      rows_r <= kmwf_pkg::ROWS_RST;
      cols_r <= kmwf_pkg::COLS_RST;
    end else begin
      st_r   <= st_nxt;
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    colsc_r <= colsc_nxt;
    n_r     <= n_nxt;
    h_r     <= h_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    c1_r    <= c1_nxt;
    c2_r    <= c2_nxt;
    bad_r   <= bad_nxt;
  end

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_ready)
    else $error("item taken during table clear");

  a_bad_cells_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && bad_r) |-> (c1_r == '0 && c2_r == '0))
    else $error("bad wall pushed with nonzero cells");

endmodule

`default_nettype wire

// ----- rtl/core/kmwf_queue.sv -----
`default_nettype none

module kmwf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = kmwf_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_pop) rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + (PW+1)'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

endmodule

`default_nettype wire

// ----- rtl/core/kmwf_back.sv -----
`default_nettype none

module kmwf_back #(
  parameter int MAX_ROWS = kmwf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = kmwf_pkg::DEF_MAX_COLS,
  localparam int SLOTS = MAX_ROWS * MAX_COLS,
  localparam int AW = $clog2(SLOTS),
  localparam int EW = 3 * AW + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire logic [EW-1:0]               q_data,
  output logic                             q_pop,
  output logic                             clear_busy,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kmwf_pkg::CELL_W-1:0]      out_first_cell,
  output logic [kmwf_pkg::CELL_W-1:0]      out_second_cell,
  output logic                             out_removed,
  output logic                             out_maze_complete,
  output logic                             out_bad_wall
);

  localparam int RANK_W = kmwf_pkg::RANK_W;
  localparam int CELL_W = kmwf_pkg::CELL_W;
  localparam int DW     = AW + 1 + RANK_W;

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_WALK = 3'd2;
  localparam logic [2:0] B_CMP  = 3'd3;
  localparam logic [2:0] B_JOIN = 3'd4;
  localparam logic [2:0] B_RANK = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]        st_r, st_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     ud_r, ud_nxt;
  logic [AW-1:0]     c1_r, c1_nxt;
  logic [AW-1:0]     c2_r, c2_nxt;
  logic [AW-1:0]     nm1_r, nm1_nxt;
  logic              bad_r, bad_nxt;
  logic              which_r, which_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     r1_r, r1_nxt;
  logic [AW-1:0]     r2_r, r2_nxt;
  logic [RANK_W-1:0] rk1_r, rk1_nxt;
  logic [RANK_W-1:0] rk2_r, rk2_nxt;
  logic              rmv_r, rmv_nxt;

  logic              ov_r, ov_nxt;
  logic [CELL_W-1:0] of_r, of_nxt;
  logic [CELL_W-1:0] os_r, os_nxt;
  logic              orm_r, orm_nxt;
  logic              ocp_r, ocp_nxt;
  logic              obd_r, obd_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DW-1:0]     ram_wdata, ram_rdata;

  logic              rd_root;
  logic [AW-1:0]     rd_link;
  logic [RANK_W-1:0] rd_rank;
  logic [AW-1:0]     q_c1, q_c2, q_nm1;
  logic              q_bad;
  logic [AW-1:0]     root_sel, top, sub;
  logic [RANK_W-1:0] rk_top, rk_sub;

  // table word: root flag, parent link, rank
  kmwf_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_root = ram_rdata[DW-1];
  assign rd_link = ram_rdata[RANK_W +: AW];
  assign rd_rank = ram_rdata[RANK_W-1:0];

  assign {q_bad, q_nm1, q_c2, q_c1} = q_data;

  assign root_sel = which_r ? r2_r : r1_r;
  assign top      = (rk1_r > rk2_r) ? r1_r : r2_r;
  assign sub      = (rk1_r > rk2_r) ? r2_r : r1_r;
  assign rk_top   = (rk1_r > rk2_r) ? rk1_r : rk2_r;
  assign rk_sub   = (rk1_r > rk2_r) ? rk2_r : rk1_r;

  assign clear_busy = (st_r == B_CLR);

  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    ud_nxt    = ud_r;
    c1_nxt    = c1_r;
    c2_nxt    = c2_r;
    nm1_nxt   = nm1_r;
    bad_nxt   = bad_r;
    which_nxt = which_r;
    addr_nxt  = addr_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    rk1_nxt   = rk1_r;
    rk2_nxt   = rk2_r;
    rmv_nxt   = rmv_r;
    ov_nxt    = ov_r && !out_ready;
    of_nxt    = of_r;
    os_nxt    = os_r;
    orm_nxt   = orm_r;
    ocp_nxt   = ocp_r;
    obd_nxt   = obd_r;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = addr_r;
    q_pop     = 1'b0;

    case (st_r)
      B_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b1, AW'(0), kmwf_pkg::RANK_INIT};
        if (clr_r == AW'(SLOTS - 1)) st_nxt = B_IDLE;
        else clr_nxt = clr_r + AW'(1);
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          c1_nxt    = q_c1;
          c2_nxt    = q_c2;
          nm1_nxt   = q_nm1;
          bad_nxt   = q_bad;
          rmv_nxt   = 1'b0;
          which_nxt = 1'b0;
          if (q_bad || ud_r >= q_nm1) begin
            st_nxt = B_OUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = q_c1;
            addr_nxt  = q_c1;
            st_nxt    = B_WALK;
          end
        end
      end
      B_WALK: begin
        // climb parent links until a root shows up
        ram_re = 1'b1;
        if (rd_root) begin
          if (which_r) begin
            r2_nxt  = addr_r;
            rk2_nxt = rd_rank;
          end else begin
            r1_nxt  = addr_r;
            rk1_nxt = rd_rank;
          end
          ram_raddr = which_r ? c2_r : c1_r;
          addr_nxt  = which_r ? c2_r : c1_r;
          st_nxt    = B_CMP;
        end else begin
          ram_raddr = rd_link;
          addr_nxt  = rd_link;
        end
      end
      B_CMP: begin
        // second walk, pointing each node on the path at the root
        if (addr_r == root_sel || rd_root) begin
          if (!which_r) begin
            which_nxt = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = c2_r;
            addr_nxt  = c2_r;
            st_nxt    = B_WALK;
          end else begin
            st_nxt = B_JOIN;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = addr_r;
          ram_wdata = {1'b0, root_sel, RANK_W'(0)};
          ram_re    = 1'b1;
          ram_raddr = rd_link;
          addr_nxt  = rd_link;
        end
      end
      B_JOIN: begin
        st_nxt = B_OUT;
        if (r1_r != r2_r) begin
          ram_we    = 1'b1;
          ram_waddr = sub;
          ram_wdata = {1'b0, top, RANK_W'(0)};
          ud_nxt    = ud_r + AW'(1);
          rmv_nxt   = 1'b1;
          if (rk_top == rk_sub && rk_top != kmwf_pkg::RANK_TOP) st_nxt = B_RANK;
        end
      end
      B_RANK: begin
        ram_we    = 1'b1;
        ram_waddr = top;
        ram_wdata = {1'b1, AW'(0), rk_top + RANK_W'(1)};
        st_nxt    = B_OUT;
      end
      B_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt  = 1'b1;
          of_nxt  = CELL_W'(c1_r);
          os_nxt  = CELL_W'(c2_r);
          orm_nxt = rmv_r;
          ocp_nxt = (ud_r >= nm1_r);
          obd_nxt = bad_r;
          st_nxt  = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  assign out_valid         = ov_r;
  assign out_first_cell    = of_r;
  assign out_second_cell   = os_r;
  assign out_removed       = orm_r;
  assign out_maze_complete = ocp_r;
  assign out_bad_wall      = obd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_CLR;
      clr_r <= '0;
      ud_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ud_r  <= ud_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c1_r    <= c1_nxt;
    c2_r    <= c2_nxt;
    nm1_r   <= nm1_nxt;
    bad_r   <= bad_nxt;
    which_r <= which_nxt;
    addr_r  <= addr_nxt;
    r1_r    <= r1_nxt;
    r2_r    <= r2_nxt;
    rk1_r   <= rk1_nxt;
    rk2_r   <= rk2_nxt;
    rmv_r   <= rmv_nxt;
    of_r    <= of_nxt;
    os_r    <= os_nxt;
    orm_r   <= orm_nxt;
    ocp_r   <= ocp_nxt;
    obd_r   <= obd_nxt;
  end

  a_bad_never_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && obd_r) |-> !orm_r)
    else $error("bad wall reported as removed");

  a_rank_after_join: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_RANK) |-> ($past(st_r) == B_JOIN))
    else $error("rank update outside a union");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == B_IDLE))
    else $error("queue popped while engine busy");

  a_union_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && ud_r != $past(ud_r)) |-> (ud_r == $past(ud_r) + AW'(1)))
    else $error("union count moved by more than one");

endmodule

`default_nettype wire

// ----- verif/kruskal_maze_wall_filter_top_tb.sv -----
`timescale 1ns / 100ps

module kruskal_maze_wall_filter_top_tb;

  localparam int ID_W       = kmwf_pkg::ID_W;
  localparam int CELL_W     = kmwf_pkg::CELL_W;
  localparam int CFG_W      = kmwf_pkg::CFG_W;
  localparam int CFG_IDX_W  = kmwf_pkg::CFG_IDX_W;
  localparam int RANK_W     = kmwf_pkg::RANK_W;
  localparam int MAX_ROWS   = kmwf_pkg::DEF_MAX_ROWS;
  localparam int MAX_COLS   = kmwf_pkg::DEF_MAX_COLS;
  localparam int CELL_SLOTS = MAX_ROWS * MAX_COLS;
  // a set link with the top bit high marks a root
  localparam logic [ID_W-1:0] NO_PARENT = 13'h1000;
  // budget for the clearing pass plus ~1100 walls
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CELL_W-1:0] first_cell;
    logic [CELL_W-1:0] second_cell;
    logic              removed;
    logic              complete;
    logic              bad;
  } wall_verdict_t;

  // shadow of the union-find forest plus the queue of verdicts still owed
  class maze_tracker;
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  cols_reg;
    logic [ID_W-1:0]   link_tab [CELL_SLOTS];
    logic [RANK_W-1:0] rank_tab [CELL_SLOTS];
    int                unions;
    int                failures;
    int                verdicts_seen;
    wall_verdict_t     expected_walls [$];

    function new();
      rows_reg = kmwf_pkg::ROWS_RST;
      cols_reg = kmwf_pkg::COLS_RST;
      for (int i = 0; i < CELL_SLOTS; i++) begin
        link_tab[i] = NO_PARENT;
        rank_tab[i] = kmwf_pkg::RANK_INIT;
      end
      unions = 0;
      failures = 0;
      verdicts_seen = 0;
    endfunction

    // zero acts as one, anything past the maximum as the maximum
    function int span(input logic [CFG_W-1:0] v, input int top);
      if (v == 0) return 1;
      if (int'(v) > top) return top;
      return int'(v);
    endfunction

    function int grid_width();
      return span(cols_reg, MAX_COLS);
    endfunction

    function int grid_cells();
      return span(rows_reg, MAX_ROWS) * grid_width();
    endfunction

    function int pending();
      return expected_walls.size();
    endfunction

    // root search, then a second walk pointing every visited node at the root
    function int root_of(input int x);
      int root;
      int cur;
      int nxt;
      int steps;
      root = x;
      steps = 0;
      while (!link_tab[root][ID_W-1] && steps < CELL_SLOTS) begin
        root = int'(link_tab[root][CELL_W-1:0]);
        steps++;
      end
      cur = x;
      steps = 0;
      while (cur != root && !link_tab[cur][ID_W-1] && steps < CELL_SLOTS) begin
        nxt = int'(link_tab[cur][CELL_W-1:0]);
        link_tab[cur] = {1'b0, root[CELL_W-1:0]};
        cur = nxt;
        steps++;
      end
      return root;
    endfunction

    // union by rank, ties go to the second root, rank saturates
    function void merge_roots(input int a, input int b);
      int top;
      int sub;
      if (rank_tab[a] > rank_tab[b]) begin
        top = a;
        sub = b;
      end else begin
        top = b;
        sub = a;
      end
      link_tab[sub] = {1'b0, top[CELL_W-1:0]};
      if (rank_tab[top] == rank_tab[sub] && rank_tab[top] < kmwf_pkg::RANK_TOP)
        rank_tab[top] = rank_tab[top] + 1'b1;
    endfunction

    function void note_wall(input logic [ID_W-1:0] wall);
      int cols;
      int n;
      int id;
      int h;
      int c1;
      int c2;
      int r1;
      int r2;
      wall_verdict_t v;
      cols = grid_width();
      n = grid_cells();
      id = int'(wall);
      c1 = 0;
      c2 = 0;
      v = '0;
      if (id < n) begin
        if (id < n - cols) begin
          c1 = id;
          c2 = id + cols;
        end else begin
          v.bad = 1'b1;
        end
      end else begin
        h = id - n;
        if (h < n && (h % cols) != cols - 1) begin
          c1 = h;
          c2 = h + 1;
        end else begin
          v.bad = 1'b1;
        end
      end
      if (!v.bad && unions < n - 1) begin
        r1 = root_of(c1);
        r2 = root_of(c2);
        if (r1 != r2) begin
          merge_roots(r1, r2);
          unions = (unions + 1) % 4096;
          v.removed = 1'b1;
        end
      end
      v.first_cell  = c1[CELL_W-1:0];
      v.second_cell = c2[CELL_W-1:0];
      v.complete    = (unions >= n - 1);
      expected_walls = {expected_walls, v};
    endfunction

    function void check_result(input wall_verdict_t got);
      wall_verdict_t want;
      verdicts_seen++;
      if (expected_walls.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("verdict %0d arrived with nothing outstanding: first %0d second %0d",
                   verdicts_seen, got.first_cell, got.second_cell);
        return;
      end
      want = expected_walls.pop_front();
      if (got.first_cell !== want.first_cell || got.second_cell !== want.second_cell ||
          got.removed !== want.removed || got.complete !== want.complete ||
          got.bad !== want.bad) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("verdict %0d expected cells %0d/%0d removed %b complete %b bad %b",
                   verdicts_seen, want.first_cell, want.second_cell, want.removed,
                   want.complete, want.bad);
          $display("verdict %0d      got cells %0d/%0d removed %b complete %b bad %b",
                   verdicts_seen, got.first_cell, got.second_cell, got.removed,
                   got.complete, got.bad);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = kmwf_pkg::REG_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ID_W-1:0]      in_wall_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    out_first_cell;
  logic [CELL_W-1:0]    out_second_cell;
  logic                 out_removed;
  logic                 out_maze_complete;
  logic                 out_bad_wall;

  maze_tracker sb;
  // when set, the wall source sends back to back for the whole phase
  bit sender_calm = 1'b0;

  kruskal_maze_wall_filter_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_wall_id        (in_wall_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_cell    (out_first_cell),
    .out_second_cell   (out_second_cell),
    .out_removed       (out_removed),
    .out_maze_complete (out_maze_complete),
    .out_bad_wall      (out_bad_wall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // one wall transfer; valid stays up across back-to-back walls
  task automatic send_wall(input logic [ID_W-1:0] wall);
    int gap;
    gap = (sender_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_wall_id <= wall;
    do @(posedge clk); while (!in_ready);
    sb.note_wall(wall);
  endtask

  // both registers in consecutive cycles, the write enable held between them
  task automatic set_grid(input logic [CFG_W-1:0] rows_val,
                          input logic [CFG_W-1:0] cols_val);
    cfg_we    <= 1'b1;
    cfg_index <= kmwf_pkg::REG_ROWS;
    cfg_data  <= rows_val;
    @(posedge clk);
    cfg_index <= kmwf_pkg::REG_COLS;
    cfg_data  <= cols_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rows_reg = rows_val;
    sb.cols_reg = cols_val;
  endtask

  // every owed verdict back; one result per wall so the engine is then idle
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // walls the block should reject, plus arbitrary ids over the full width
  function automatic logic [ID_W-1:0] noise_id(input int n, input int cols);
    case ($urandom_range(0, 2))
      0: return ID_W'($urandom_range(0, (1 << ID_W) - 1));
      1: return ID_W'($urandom_range(0, 2 * n - 1));
      default: begin
        if ($urandom_range(0, 1))
          return ID_W'($urandom_range(n - cols, n - 1));
        return ID_W'(n + $urandom_range(0, n / cols - 1) * cols + cols - 1);
      end
    endcase
  endfunction

  // a wall that lies inside the grid; the grid must have at least two cells
  function automatic logic [ID_W-1:0] pick_valid(input int n, input int cols);
    int h;
    if (cols == 1 || (n / cols > 1 && $urandom_range(0, 1)))
      return ID_W'($urandom_range(0, n - cols - 1));
    h = $urandom_range(0, n - 1);
    if (h % cols == cols - 1) h--;
    return ID_W'(n + h);
  endfunction

  // every id of the grid in random order, as a shuffling front end would send them
  task automatic play_shuffled();
    int n;
    int cols;
    int i;
    int j;
    int tmp;
    int ids [$];
    n = sb.grid_cells();
    cols = sb.grid_width();
    for (i = 0; i < 2 * n; i++) ids = {ids, i};
    for (i = 2 * n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    sender_calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < ids.size(); i++) begin
      if ($urandom_range(0, 9) == 0) send_wall(noise_id(n, cols));
      send_wall(ID_W'(ids[i]));
    end
    in_valid <= 1'b0;
  endtask

  task automatic play_random(input int count, input int valid_pct);
    int n;
    int cols;
    int i;
    n = sb.grid_cells();
    cols = sb.grid_width();
    sender_calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < count; i++) begin
      if (n > 1 && $urandom_range(0, 99) < valid_pct) send_wall(pick_valid(n, cols));
      else send_wall(noise_id(n, cols));
    end
    in_valid <= 1'b0;
  endtask

  // result side: check every transfer, stall in bursts with quiet stretches between
  initial begin : result_side
    int stall;
    int mode_left;
    bit calm;
    wall_verdict_t got;
    stall = 0;
    mode_left = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.first_cell  = out_first_cell;
        got.second_cell = out_second_cell;
        got.removed     = out_removed;
        got.complete    = out_maze_complete;
        got.bad         = out_bad_wall;
        sb.check_result(got);
      end
      if (mode_left <= 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) stall = idle_len();
      end
    end
  end

  // watchdog covers the clearing pass after reset too
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("kruskal_maze_wall_filter_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed walls on the reset grid of 8 by 8 (64 cells)
    send_wall(13'd0);     // first vertical wall, cells 0 and 8
    send_wall(13'd0);     // same wall again, roots now equal
    send_wall(13'd55);    // last vertical wall above the bottom row
    send_wall(13'd56);    // vertical id in the bottom row
    send_wall(13'd63);
    send_wall(13'd64);    // first horizontal wall, cells 0 and 1
    send_wall(13'd71);    // horizontal id in the right-hand column
    send_wall(13'd72);    // cells 8 and 9
    send_wall(13'd1);     // cells 1 and 9 already joined, so a cycle
    send_wall(13'd65);    // cells 1 and 2
    send_wall(13'd2);     // cells 2 and 10
    send_wall(13'd10);    // cells 10 and 18
    send_wall(13'd66);    // cells 2 and 3
    send_wall(13'd3);     // cells 3 and 11, lengthens the path
    send_wall(13'd82);    // cells 18 and 19
    send_wall(13'd11);    // 11 and 19 already joined via compressed paths
    send_wall(13'd126);   // last horizontal wall, cells 62 and 63
    send_wall(13'd127);   // one past it
    send_wall(13'd128);   // first id at twice the cell count
    send_wall(13'h0AAA);
    send_wall(13'h1555);
    send_wall(13'h1000);
    send_wall(13'h1FFF);  // top of the id range
    in_valid <= 1'b0;
    settle();

    // one row of three, zero rows reads as one; the maze is already complete
    set_grid(7'd0, 7'd3);
    play_shuffled();
    settle();

    // rows past the maximum, a single column: only vertical walls exist
    set_grid(7'd127, 7'd1);
    play_shuffled();
    settle();

    // growing grids over the carried-over forest, each run to completion
    set_grid(7'($urandom_range(9, 11)), 7'($urandom_range(9, 12)));
    play_shuffled();
    settle();

    set_grid(7'($urandom_range(13, 16)), 7'($urandom_range(13, 16)));
    play_shuffled();
    settle();

    // largest grid, a sample only: reaches the high cell numbers
    set_grid(7'd64, 7'd64);
    play_random(80, 85);
    settle();

    // a single cell has no wall at all
    set_grid(7'd1, 7'd1);
    play_random(20, 0);
    settle();

    // two rows, columns past the maximum; already complete, so all kept
    set_grid(7'd2, 7'd65);
    play_random(60, 85);
    settle();

    repeat (60) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("kruskal_maze_wall_filter_top: match");
    end else begin
      $display("kruskal_maze_wall_filter_top: mismatch");
    end
    $finish;
  end

endmodule
